>>> rtl/neighbourhood_component_counter_unit_macros.svh
// Assertion macros for the neighbourhood component counter checker.
// Included by the checker file only; relies on a clk and rst in scope.
`ifndef NEIGHBOURHOOD_COMPONENT_COUNTER_UNIT_MACROS_SVH
`define NEIGHBOURHOOD_COMPONENT_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ncc_pkg.sv
// Shared types, constants and adjacency tables of the component counter.
// Used by the controller, the datapath and the top level.
package ncc_pkg;

  localparam int NumVoxels = 27;
  localparam int CentreVoxel = 13;
  localparam int CountWidth = 4;

  localparam logic [1:0] MODE_26_ALL  = 2'd0;
  localparam logic [1:0] MODE_6_FACE  = 2'd1;
  localparam logic [1:0] MODE_6_ALL   = 2'd2;

  localparam logic [NumVoxels-1:0] ALL_VOXELS = {NumVoxels{1'b1}};
  localparam logic [NumVoxels-1:0] FACE_SEEDS = 27'h0415410;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new neighbourhood and its seed set
    logic pick;    // start a component at the lowest pending seed
    logic step;    // grow the current component by one adjacency ring
    logic retire;  // drop the finished component from the seeds, count it
    logic emit;    // copy the count into the output register
  } ncc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pending_empty;  // no seeds left
    logic flood_stable;   // growth added nothing this cycle
  } ncc_status_t;

  // Mask of the voxels adjacent to voxel v; wide selects 26-adjacency
  // with an isolated centre, otherwise face adjacency.
  function automatic logic [NumVoxels-1:0] nbr_mask(input int v, input logic wide);
    logic [NumVoxels-1:0] m;
    int vx, vy, vz, ux, uy, uz, dx, dy, dz;
    m  = '0;
    vx = v % 3;
    vy = (v / 3) % 3;
    vz = v / 9;
    for (int u = 0; u < NumVoxels; u++) begin
      ux = u % 3;
      uy = (u / 3) % 3;
      uz = u / 9;
      dx = (ux > vx) ? ux - vx : vx - ux;
      dy = (uy > vy) ? uy - vy : vy - uy;
      dz = (uz > vz) ? uz - vz : vz - uz;
      if (u != v) begin
        if (wide) begin
          if (v != CentreVoxel && u != CentreVoxel && dx <= 1 && dy <= 1 && dz <= 1)
            m[u] = 1'b1;
        end else if (dx + dy + dz == 1) begin
          m[u] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/ncc_ctrl.sv
// Sequencing state machine of the component counter.
// Depends on ncc_pkg for the command and status structs.
module ncc_ctrl import ncc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  ncc_status_t status,
  output ncc_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PICK  = 2'd1;
  localparam logic [1:0] S_FLOOD = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state, state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Decode state into datapath commands and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (status.pending_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.pick   = 1'b1;
          state_next = S_FLOOD;
        end
      end
      S_FLOOD: begin
        if (status.flood_stable) begin
          cmd.retire = 1'b1;
          state_next = S_PICK;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the result beat until it is taken.
  always_comb begin
    priority if (cmd.emit) out_valid_next = 1'b1;
    else if (!out_stall)   out_valid_next = 1'b0;
    else                   out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/ncc_datapath.sv
// Masks, flood logic, counter and mode register of the component counter.
// Depends on ncc_pkg for adjacency tables, modes and the command structs.
module ncc_datapath import ncc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  connectivity_mode_we,
  input  logic [1:0]            connectivity_mode,
  input  logic [NumVoxels-1:0]  neighbourhood,
  input  ncc_cmd_t              cmd,
  output ncc_status_t           status,
  output logic [CountWidth-1:0] component_count
);

  logic [1:0]            mode;
  logic [NumVoxels-1:0]  fg;
  logic [NumVoxels-1:0]  pending;
  logic [NumVoxels-1:0]  comp;
  logic [NumVoxels-1:0]  grow;
  logic [NumVoxels-1:0]  seeds;
  logic [NumVoxels-1:0]  lowest;
  logic [CountWidth-1:0] count;
  logic                  wide;

  assign wide = (mode == MODE_26_ALL);

  // Select the seed set for the current mode; the unused code seeds nothing.
  always_comb begin
    unique case (mode)
      MODE_26_ALL: seeds = ALL_VOXELS;
      MODE_6_FACE: seeds = FACE_SEEDS;
      MODE_6_ALL:  seeds = ALL_VOXELS;
      default:     seeds = '0;
    endcase
  end

  // Isolate the lowest pending seed.
  assign lowest = pending & (~pending + {{(NumVoxels-1){1'b0}}, 1'b1});

  // Grow by one ring: a foreground voxel joins if any neighbour is in comp.
  for (genvar u = 0; u < NumVoxels; u++) begin : g_grow
    localparam logic [NumVoxels-1:0] NbrWide = nbr_mask(u, 1'b1);
    localparam logic [NumVoxels-1:0] NbrFace = nbr_mask(u, 1'b0);
    assign grow[u] = fg[u] & (|(comp & (wide ? NbrWide : NbrFace)));
  end

  assign status.pending_empty = (pending == '0);
  assign status.flood_stable  = ((comp | grow) == comp);

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_26_ALL;
    end else if (connectivity_mode_we) begin
      mode <= connectivity_mode;
    end
  end

  // Advance masks and counter under controller command.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fg      <= neighbourhood;
      pending <= neighbourhood & seeds;
      count   <= '0;
    end
    if (cmd.pick) begin
      comp <= lowest;
    end
    if (cmd.step) begin
      comp <= comp | grow;
    end
    if (cmd.retire) begin
      pending <= pending & ~comp;
      count   <= count + {{(CountWidth-1){1'b0}}, 1'b1};
    end
    if (cmd.emit) begin
      component_count <= count;
    end
  end

endmodule

>>> rtl/neighbourhood_component_counter_unit.sv
// Top level of the 3x3x3 neighbourhood component counter.
// Instantiates ncc_ctrl and ncc_datapath; depends on ncc_pkg.
//
// Counts the connected components of the set voxels in one 27-bit
// neighbourhood (voxel x+3y+9z, centre 13) under the rule that
// connectivity_mode selects: 0 = 26-adjacency with an isolated centre,
// 1 = 6-adjacency counting only components that touch a face neighbour,
// 2 = 6-adjacency counting all components, 3 = always zero. One item is
// processed at a time, since a single shared flood unit grows one component
// by one adjacency ring per cycle. A finished result waits in an output
// register, so the next item is accepted while it is still stalled. Write
// connectivity_mode only while the block is idle.
module neighbourhood_component_counter_unit import ncc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  connectivity_mode_we,
  input  logic [1:0]            connectivity_mode,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [NumVoxels-1:0]  neighbourhood,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CountWidth-1:0] component_count
);

  ncc_cmd_t    cmd;
  ncc_status_t status;

  ncc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ncc_datapath u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .connectivity_mode_we (connectivity_mode_we),
    .connectivity_mode    (connectivity_mode),
    .neighbourhood        (neighbourhood),
    .cmd                  (cmd),
    .status               (status),
    .component_count      (component_count)
  );

endmodule

>>> rtl/ncc_checker.sv
// Port-level checker for the neighbourhood component counter, and its bind.
// Depends on ncc_pkg and the assertion macros header.
`include "neighbourhood_component_counter_unit_macros.svh"

module ncc_checker import ncc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CountWidth-1:0] component_count
);

  // A stalled result beat holds.
  `NCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(component_count), "stalled result beat changed")

  // At most 14 components fit in a 3x3x3 neighbourhood.
  `NCC_ASSERT_NOW(a_count_range, out_valid, component_count <= 4'd14, "component count out of range")

  // The block is busy right after it accepts a beat.
  `NCC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "ready again right after accept")

endmodule

bind neighbourhood_component_counter_unit ncc_checker u_ncc_checker (.*);

>>> tb/neighbourhood_component_counter_unit_checker.sv
// Checker for the neighbourhood component counter: watches both beats and the mode write,
// predicts each component count and compares it with what the block returns.
// Depends on ncc_pkg for widths, mode codes and the face seed mask.
`timescale 1ns / 100ps

module neighbourhood_component_counter_unit_checker import ncc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mode_we,
  input  logic [1:0]            mode_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [NumVoxels-1:0]  neighbourhood,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CountWidth-1:0] component_count,
  output int                    mismatches,
  output int                    outstanding,
  output int                    checked
);

  // Voxels on the low and high face of the x and y axes, used to stop shifts wrapping rows.
  localparam logic [NumVoxels-1:0] X_LO = 27'h1249249;
  localparam logic [NumVoxels-1:0] X_HI = 27'h4924924;
  localparam logic [NumVoxels-1:0] Y_LO = 27'h01C0E07;
  localparam logic [NumVoxels-1:0] Y_HI = 27'h70381C0;
  localparam logic [NumVoxels-1:0] CENTRE_BIT = 27'd1 << CentreVoxel;

  typedef struct {
    logic [NumVoxels-1:0]  voxels;
    logic [1:0]            mode;
    logic [CountWidth-1:0] count;
  } count_entry_t;

  count_entry_t   expected_counts[$];
  logic [1:0]     mode_q;

  // Dilate a mask by one ring: face shifts only, or a separable 3x3x3 box when wide.
  function automatic logic [NumVoxels-1:0] one_ring(input logic [NumVoxels-1:0] m,
                                                    input logic wide);
    logic [NumVoxels-1:0] sx, sy;
    sx = ((m << 1) & ~X_LO) | ((m >> 1) & ~X_HI);
    if (!wide)
      return m | sx | ((m << 3) & ~Y_LO) | ((m >> 3) & ~Y_HI) | (m << 9) | (m >> 9);
    sx = sx | m;
    sy = sx | ((sx << 3) & ~Y_LO) | ((sx >> 3) & ~Y_HI);
    return sy | (sy << 9) | (sy >> 9);
  endfunction

  // Flood from a seed until nothing new joins; in wide mode the centre neither joins nor spreads.
  function automatic logic [NumVoxels-1:0] grow_region(input logic [NumVoxels-1:0] fg,
                                                       input logic [NumVoxels-1:0] seed,
                                                       input logic wide);
    logic [NumVoxels-1:0] region, prev, blocked;
    blocked = wide ? CENTRE_BIT : '0;
    region  = seed;
    do begin
      prev   = region;
      region = region | (one_ring(region & ~blocked, wide) & fg & ~blocked);
    end while (region != prev);
    return region;
  endfunction

  // Count components reachable from the seed set that the mode selects.
  function automatic logic [CountWidth-1:0] count_voxel_components(
      input logic [NumVoxels-1:0] fg, input logic [1:0] mode);
    logic [NumVoxels-1:0] pending, lowest;
    logic                 wide;
    int                   n;
    case (mode)
      MODE_26_ALL: begin
        pending = fg;
        wide    = 1'b1;
      end
      MODE_6_FACE: begin
        pending = fg & FACE_SEEDS;
        wide    = 1'b0;
      end
      MODE_6_ALL: begin
        pending = fg;
        wide    = 1'b0;
      end
      default: return '0;
    endcase
    n = 0;
    while (pending != '0) begin
      lowest  = pending & (~pending + 1'b1);
      pending = pending & ~grow_region(fg, lowest, wide);
      n++;
    end
    return n[CountWidth-1:0];
  endfunction

  // Track the mode, queue a prediction per input beat, check each output beat.
  always @(posedge clk) begin
    count_entry_t entry;
    if (rst) begin
      mode_q = MODE_26_ALL;
      expected_counts.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (in_valid && !in_stall) begin
        entry.voxels = neighbourhood;
        entry.mode   = mode_q;
        entry.count  = count_voxel_components(neighbourhood, mode_q);
        expected_counts.push_back(entry);
      end
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected component_count beat, expected none, actual %0d",
                   $time, component_count);
        end else begin
          entry = expected_counts.pop_front();
          checked++;
          if (component_count !== entry.count) begin
            mismatches++;
            $display("%0t: component_count for %h in mode %0d: expected %0d, actual %0d",
                     $time, entry.voxels, entry.mode, entry.count, component_count);
          end
        end
      end
      if (mode_we)
        mode_q = mode_wdata;
    end
    outstanding = expected_counts.size();
  end

endmodule

>>> tb/neighbourhood_component_counter_unit_tb.sv
// Testbench top for the neighbourhood component counter: clock, reset, stimulus and verdict.
// Depends on ncc_pkg, the block and neighbourhood_component_counter_unit_checker.
`timescale 1ns / 100ps

module neighbourhood_component_counter_unit_tb;
  import ncc_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         NUM_PHASES   = 7;
  localparam int         NUM_PATTERNS = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  connectivity_mode_we = 1'b0;
  logic [1:0]            connectivity_mode = MODE_26_ALL;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [NumVoxels-1:0]  neighbourhood = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CountWidth-1:0] component_count;

  logic idle_on = 1'b1;
  int   squeeze_req = 0;
  int   mismatches, outstanding, checked;
  int   items_sent = 0;
  int   directed_sent = 0;
  int   quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  neighbourhood_component_counter_unit i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .connectivity_mode_we (connectivity_mode_we),
    .connectivity_mode    (connectivity_mode),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .neighbourhood        (neighbourhood),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .component_count      (component_count)
  );

  neighbourhood_component_counter_unit_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .mode_we         (connectivity_mode_we),
    .mode_wdata      (connectivity_mode),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .neighbourhood   (neighbourhood),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .component_count (component_count),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .checked         (checked)
  );

  // Offer one beat, with an occasional gap in front, and hold it until accepted.
  task automatic send_neighbourhood(input logic [NumVoxels-1:0] voxels);
    if (idle_on && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    neighbourhood <= voxels;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drain every pending count, then write the mode register.
  task automatic write_mode(input logic [1:0] mode);
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
    connectivity_mode_we <= 1'b1;
    connectivity_mode    <= mode;
    @(posedge clk);
    connectivity_mode_we <= 1'b0;
  endtask

  // Mix of densities so that counts span from zero to the isolated-voxel extremes.
  function automatic logic [NumVoxels-1:0] random_neighbourhood();
    logic [NumVoxels-1:0] a, b, c;
    a = NumVoxels'($urandom);
    b = NumVoxels'($urandom);
    c = NumVoxels'($urandom);
    case ($urandom_range(3))
      0: return a;
      1: return a & b;
      2: return a & b & c;
      default: return a | b;
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    int squeeze_seen;
    hold_left    = 0;
    squeeze_seen = 0;
    forever begin
      @(posedge clk);
      if (squeeze_req != squeeze_seen) begin
        squeeze_seen = squeeze_req;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 12);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL neighbourhood_component_counter_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed patterns per mode, then random phases across all modes.
  initial begin
    logic [NumVoxels-1:0] patterns[NUM_PATTERNS];
    logic [NumVoxels-1:0] even_mask;
    int                   directed_per_mode[4];
    logic [1:0]           phase_mode[NUM_PHASES];
    int                   phase_items[NUM_PHASES];

    even_mask = '0;
    for (int v = 0; v < NumVoxels; v++)
      if (((v % 3) + ((v / 3) % 3) + (v / 9)) % 2 == 0)
        even_mask[v] = 1'b1;
    patterns[0] = '0;
    patterns[1] = ALL_VOXELS;
    patterns[2] = even_mask;               // no two voxels face-adjacent
    patterns[3] = ALL_VOXELS & ~even_mask; // all edge voxels and the centre
    patterns[4] = 27'd1 << CentreVoxel;
    patterns[5] = FACE_SEEDS;
    patterns[6] = 27'h79C81E7;             // long path, deep flood
    patterns[7] = 27'h5140145;             // corners only
    directed_per_mode = '{8, 7, 6, 3};
    phase_mode  = '{MODE_6_ALL, MODE_26_ALL, MODE_6_FACE, MODE_UNUSED,
                    MODE_6_FACE, MODE_26_ALL, MODE_6_ALL};
    phase_items = '{100, 100, 100, 20, 60, 60, 60};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int m = 0; m < 4; m++) begin
      write_mode(m[1:0]);
      for (int k = 0; k < directed_per_mode[m]; k++)
        send_neighbourhood(patterns[k]);
    end
    directed_sent = items_sent;

    // One phase runs with no idling on either side; the first one squeezes the output.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mode(phase_mode[p]);
      idle_on <= (p != 4);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 0 && i == 30)
          squeeze_req <= squeeze_req + 1;
        send_neighbourhood(random_neighbourhood());
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d neighbourhoods (%0d directed) across all four modes, %0d counts checked,",
             items_sent, directed_sent, checked);
    $display("with random gaps on both sides and one %0d-cycle output hold-off.", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS neighbourhood_component_counter_unit");
    end else begin
      $display("FAIL neighbourhood_component_counter_unit");
    end
    $finish;
  end

endmodule
